### hw/rtl/gspf_pkg.sv
`default_nettype none

package gspf_pkg;

    // frame and sample geometry
    localparam int MAX_DIM         = 1024;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int POS_WIDTH       = $clog2(MAX_DIM);
    localparam int DIM_WIDTH       = 11;
    localparam int TDATA_WIDTH     = 24;
    localparam int PAD_WIDTH       = TDATA_WIDTH - 2 * DIM_WIDTH;
    localparam int TUSER_WIDTH     = 2;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int WIN_CELLS       = 9;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FRAME_ROWS = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FRAME_COLS = CFG_INDEX_WIDTH'(1);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [DIM_WIDTH-1:0]           dim_t;
    typedef logic [POS_WIDTH-1:0]           pos_idx_t;
    typedef sample_t                        win_t [WIN_CELLS];

    // position of one sample in the frame
    typedef struct packed {
        pos_idx_t row;
        pos_idx_t col;
        logic     last_row;
        logic     last_col;
    } pos_t;

    // sample leaving the line store, with the two samples above it
    typedef struct packed {
        pos_t    pos;
        sample_t top;
        sample_t mid;
        sample_t cur;
    } line_item_t;

    // one decision of the window stage
    typedef struct packed {
        logic emit;
        logic peak_valid;
        dim_t peak_row;
        dim_t peak_col;
        logic frame_end;
        logic no_peak_found;
    } result_t;

    // register value to effective frame dimension
    function automatic dim_t dim_clamp(input dim_t v);
        dim_t res;
        if (v == '0) begin
            res = DIM_WIDTH'(1);
        end else if (v > DIM_WIDTH'(MAX_DIM)) begin
            res = DIM_WIDTH'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/gspf_line_store.sv
`default_nettype none

module gspf_line_store (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_accept,
    input  wire gspf_pkg::pos_t      in_pos,
    input  wire gspf_pkg::sample_t   in_height,
    input  wire logic                s1_valid,
    input  wire logic                s1_adv,
    output gspf_pkg::line_item_t     s1_item
);

    gspf_pkg::sample_t newer_mem [gspf_pkg::MAX_DIM];
    gspf_pkg::sample_t older_mem [gspf_pkg::MAX_DIM];

    gspf_pkg::sample_t newer_rd_reg;
    gspf_pkg::sample_t older_rd_reg;
    gspf_pkg::pos_t    pos_reg;
    gspf_pkg::sample_t cur_reg;
    logic              fwd_reg;
    logic              fwd_next;
    gspf_pkg::sample_t fwd_data_reg;

    // newer line: read old value and store the new sample at the same column
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            newer_rd_reg                <= newer_mem[in_pos.col];
            newer_mem[in_pos.col]       <= in_height;
        end
    end

    // older line: read on accept, takes the middle sample when it moves on
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            older_rd_reg <= older_mem[in_pos.col];
        end
        if (s1_adv) begin
            older_mem[pos_reg.col] <= newer_rd_reg;
        end
    end

    // bypass when the older line is written and read at one column together
    assign fwd_next = s1_valid && s1_adv && (pos_reg.col == in_pos.col);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (in_accept) begin
            fwd_reg <= fwd_next;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            pos_reg      <= in_pos;
            cur_reg      <= in_height;
            fwd_data_reg <= newer_rd_reg;
        end
    end

    always_comb begin
        s1_item.pos = pos_reg;
        s1_item.top = fwd_reg ? fwd_data_reg : older_rd_reg;
        s1_item.mid = newer_rd_reg;
        s1_item.cur = cur_reg;
    end

endmodule

`default_nettype wire

### hw/rtl/gspf_peak_judge.sv
`default_nettype none

module gspf_peak_judge (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s1_adv,
    input  wire gspf_pkg::line_item_t  s1_item,
    input  wire logic                  s2_adv,
    input  wire logic                  restart,
    output gspf_pkg::result_t          result
);

    gspf_pkg::win_t win_reg;
    gspf_pkg::win_t win_next;
    gspf_pkg::pos_t pos_reg;
    logic           any_peak_reg;
    logic           any_peak_next;

    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic       cand_a;
    logic       cand_b;
    logic       cand_c;
    logic       cand_d;
    logic       last;
    logic       found;
    gspf_pkg::dim_t row_dim;
    gspf_pkg::dim_t col_dim;

    // strict peak test of one window cell against its in-frame neighbors
    function automatic logic is_peak(input gspf_pkg::win_t win, input int wr, input int wc,
                                     input logic [2:0] rok, input logic [2:0] cok);
        logic ok;
        int   nr;
        int   nc;
        ok = 1'b1;
        for (nr = 0; nr < 3; nr++) begin
            for (nc = 0; nc < 3; nc++) begin
                if ((nr != wr || nc != wc) && (nr - wr <= 1) && (wr - nr <= 1)
                        && (nc - wc <= 1) && (wc - nc <= 1) && rok[nr] && cok[nc]) begin
                    if (win[nr * 3 + nc] >= win[wr * 3 + wc]) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

    // window shift: new column from the line store on the right
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[i * 3 + 0] = win_reg[i * 3 + 1];
            win_next[i * 3 + 1] = win_reg[i * 3 + 2];
        end
        win_next[2] = s1_item.top;
        win_next[5] = s1_item.mid;
        win_next[8] = s1_item.cur;
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            win_reg <= win_next;
            pos_reg <= s1_item.pos;
        end
    end

    // masks for window rows and columns that lie before the frame start
    always_comb begin
        row_ok = {1'b1, pos_reg.row != '0, pos_reg.row > gspf_pkg::POS_WIDTH'(1)};
        col_ok = {1'b1, pos_reg.col != '0, pos_reg.col > gspf_pkg::POS_WIDTH'(1)};
    end

    // cells decided by this sample, in raster order
    always_comb begin
        last   = pos_reg.last_row && pos_reg.last_col;
        cand_a = row_ok[1] && col_ok[1] && is_peak(win_reg, 1, 1, row_ok, col_ok);
        cand_b = row_ok[1] && pos_reg.last_col && is_peak(win_reg, 1, 2, row_ok, col_ok);
        cand_c = pos_reg.last_row && col_ok[1] && is_peak(win_reg, 2, 1, row_ok, col_ok);
        cand_d = last && is_peak(win_reg, 2, 2, row_ok, col_ok);
        found  = cand_a || cand_b || cand_c || cand_d;
        row_dim = gspf_pkg::DIM_WIDTH'(pos_reg.row);
        col_dim = gspf_pkg::DIM_WIDTH'(pos_reg.col);
    end

    always_comb begin
        result.emit          = found || last;
        result.peak_valid    = found;
        result.frame_end     = last;
        result.no_peak_found = last && !(any_peak_reg || found);
        result.peak_row      = '0;
        result.peak_col      = '0;
        priority if (cand_a) begin
            result.peak_row = row_dim;
            result.peak_col = col_dim;
        end else if (cand_b) begin
            result.peak_row = row_dim;
            result.peak_col = col_dim + gspf_pkg::DIM_WIDTH'(1);
        end else if (cand_c) begin
            result.peak_row = row_dim + gspf_pkg::DIM_WIDTH'(1);
            result.peak_col = col_dim;
        end else if (cand_d) begin
            result.peak_row = row_dim + gspf_pkg::DIM_WIDTH'(1);
            result.peak_col = col_dim + gspf_pkg::DIM_WIDTH'(1);
        end else begin
            result.peak_row = '0;
            result.peak_col = '0;
        end
    end

    // per-frame peak flag
    always_comb begin
        any_peak_next = any_peak_reg;
        if (restart) begin
            any_peak_next = 1'b0;
        end else if (s2_adv) begin
            any_peak_next = last ? 1'b0 : (any_peak_reg || found);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_peak_reg <= 1'b0;
        end else begin
            any_peak_reg <= any_peak_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/grid_strict_peak_finder_unit.sv
// Strict 3x3 peak finder for a height grid streamed in raster order.
// s_ channel: one signed 16-bit height sample per transaction, left to right,
// top to bottom. m_ channel: one transaction per peak found, and one on the last
// sample of every frame, shared with a peak found there (tlast set, tuser[1] set
// when the frame had no peak). Peaks come out in raster order with 1-based row and column.
// cfg channel: index 0 sets frame_rows, index 1 sets frame_cols (0 acts as 1,
// values above 1024 act as 1024); a write to either restarts the frame.
// Write configuration only while the block is idle; cfg_ready is always high.
// Throughput: one sample per cycle, sustained while the output is not blocked.
// Path: the edge that accepts a sample reads the line store, then the window
// shift and the result register follow before the result shows on m_tvalid.
// Reset: frame size 1024 x 1024, position at row 0 column 0, pipeline empty.
// The line stores are not cleared; rows not yet written are masked off.
// When m_tready is low the result register holds, the stages behind it fill,
// and s_tready drops once all three are occupied; nothing is dropped.
`default_nettype none

module grid_strict_peak_finder_unit (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // input samples
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    input  wire logic [gspf_pkg::SAMPLE_WIDTH-1:0]       s_tdata,  // height
    // results
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    output logic [gspf_pkg::TDATA_WIDTH-1:0]             m_tdata,  // peak_row, peak_col, zero pad
    output logic [gspf_pkg::TUSER_WIDTH-1:0]             m_tuser,  // peak_valid, no_peak_found
    output logic                                         m_tlast,  // frame_end
    // configuration writes
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [gspf_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [gspf_pkg::DIM_WIDTH-1:0]          cfg_data
);

    gspf_pkg::dim_t     rows_reg;
    gspf_pkg::dim_t     cols_reg;
    gspf_pkg::pos_idx_t row_reg;
    gspf_pkg::pos_idx_t col_reg;
    gspf_pkg::pos_t     in_pos;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    gspf_pkg::result_t out_res_reg;

    logic in_accept;
    logic cfg_write;
    logic restart;
    logic out_free;
    logic s2_free;
    logic s1_adv;
    logic s2_adv;

    gspf_pkg::line_item_t s1_item;
    gspf_pkg::result_t    s2_result;

    // handshake chain
    assign out_free  = !out_valid_reg || m_tready;
    assign s2_adv    = s2_valid_reg && out_free;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_adv    = s1_valid_reg && s2_free;
    assign s_tready  = !s1_valid_reg || s2_free;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write
                       && (cfg_index == gspf_pkg::CFG_FRAME_ROWS
                           || cfg_index == gspf_pkg::CFG_FRAME_COLS);

    // frame size registers, stored already clamped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= gspf_pkg::DIM_WIDTH'(gspf_pkg::MAX_DIM);
            cols_reg <= gspf_pkg::DIM_WIDTH'(gspf_pkg::MAX_DIM);
        end else if (cfg_write) begin
            if (cfg_index == gspf_pkg::CFG_FRAME_ROWS) begin
                rows_reg <= gspf_pkg::dim_clamp(cfg_data);
            end
            if (cfg_index == gspf_pkg::CFG_FRAME_COLS) begin
                cols_reg <= gspf_pkg::dim_clamp(cfg_data);
            end
        end
    end

    // position of the incoming sample
    always_comb begin
        in_pos.row      = row_reg;
        in_pos.col      = col_reg;
        in_pos.last_row = (gspf_pkg::DIM_WIDTH'(row_reg) + gspf_pkg::DIM_WIDTH'(1)) == rows_reg;
        in_pos.last_col = (gspf_pkg::DIM_WIDTH'(col_reg) + gspf_pkg::DIM_WIDTH'(1)) == cols_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (restart) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (in_accept) begin
            if (in_pos.last_col) begin
                col_reg <= '0;
                row_reg <= in_pos.last_row ? '0 : row_reg + gspf_pkg::POS_WIDTH'(1);
            end else begin
                col_reg <= col_reg + gspf_pkg::POS_WIDTH'(1);
            end
        end
    end

    // stage occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= in_accept;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_adv;
            end
            if (out_free) begin
                out_valid_reg <= s2_valid_reg && s2_result.emit;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_res_reg <= s2_result;
        end
    end

    gspf_line_store u_line_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_pos    (in_pos),
        .in_height (gspf_pkg::sample_t'(s_tdata)),
        .s1_valid  (s1_valid_reg),
        .s1_adv    (s1_adv),
        .s1_item   (s1_item)
    );

    gspf_peak_judge u_peak_judge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1_adv   (s1_adv),
        .s1_item  (s1_item),
        .s2_adv   (s2_adv),
        .restart  (restart),
        .result   (s2_result)
    );

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{gspf_pkg::PAD_WIDTH{1'b0}}, out_res_reg.peak_col, out_res_reg.peak_row};
    assign m_tuser  = {out_res_reg.no_peak_found, out_res_reg.peak_valid};
    assign m_tlast  = out_res_reg.frame_end;

`ifndef SYNTHESIS
    // a reported peak always names a real cell
    a_peak_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.peak_valid)
            |-> (out_res_reg.peak_row != '0 && out_res_reg.peak_col != '0))
        else $error("peak reported at row or column zero");

    // no-peak flag only on a frame end
    a_no_peak_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.no_peak_found) |-> out_res_reg.frame_end)
        else $error("no_peak_found without frame_end");

    // full pipeline with a blocked output must refuse input
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s2_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline blocked");

    // row and column position stay inside the frame
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (gspf_pkg::DIM_WIDTH'(col_reg) < cols_reg)
            && (gspf_pkg::DIM_WIDTH'(row_reg) < rows_reg))
        else $error("position outside frame");
`endif

endmodule

`default_nettype wire
